// ===== rtl/core/hrlp_pkg.sv =====
// shared types, phase codes and byte constants for the request line parser
`default_nettype none

package hrlp_pkg;

	localparam int MAX_METHOD_LEN = 16;
	localparam int COUNT_W        = $clog2(MAX_METHOD_LEN + 1);

	typedef enum logic [4:0] {
		PH_NOT_STARTED = 5'd0,
		PH_METHOD      = 5'd1,
		PH_SP_PATH     = 5'd2,
		PH_PATH        = 5'd3,
		PH_H           = 5'd4,
		PH_HT          = 5'd5,
		PH_HTT         = 5'd6,
		PH_HTTP        = 5'd7,
		PH_SLASH       = 5'd8,
		PH_MAJOR       = 5'd9,
		PH_DOT         = 5'd10,
		PH_MINOR       = 5'd11,
		PH_AFTER       = 5'd12,
		PH_END_R       = 5'd13,
		PH_END_N       = 5'd14,
		PH_HEADER      = 5'd15,
		PH_BODY        = 5'd16,
		PH_END         = 5'd17
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_METHOD = 2'd1,
		KIND_PATH   = 2'd2,
		KIND_HEADER = 2'd3
	} kind_t;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;

	typedef struct packed {
		phase_t               phase;
		logic [COUNT_W-1:0]   method_count;
		logic                 error_seen;
	} parse_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/hrlp_step.sv =====
// next-state and byte classification logic for one request byte
`default_nettype none

module hrlp_step
	import hrlp_pkg::*;
(
	input  wire logic [7:0]   rx_byte,
	input  wire parse_state_t cur,
	output parse_state_t      nxt,
	output kind_t             kind
);

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_METHOD_LEN);

	logic       expect_ok;
	logic [7:0] expect_ch;
	phase_t     expect_next;
	logic       is_expect;

	always_comb begin
		is_expect   = 1'b1;
		expect_ch   = CH_H;
		expect_next = PH_HT;
		case (cur.phase)
			PH_H: begin
				expect_ch   = CH_H;
				expect_next = PH_HT;
			end
			PH_HT: begin
				expect_ch   = CH_T;
				expect_next = PH_HTT;
			end
			PH_HTT: begin
				expect_ch   = CH_T;
				expect_next = PH_HTTP;
			end
			PH_HTTP: begin
				expect_ch   = CH_P;
				expect_next = PH_SLASH;
			end
			PH_SLASH: begin
				expect_ch   = CH_SLASH;
				expect_next = PH_MAJOR;
			end
			PH_MAJOR: begin
				expect_ch   = CH_ONE;
				expect_next = PH_DOT;
			end
			PH_DOT: begin
				expect_ch   = CH_DOT;
				expect_next = PH_MINOR;
			end
			PH_MINOR: begin
				expect_ch   = CH_ONE;
				expect_next = PH_AFTER;
			end
			PH_END_R: begin
				expect_ch   = CH_LF;
				expect_next = PH_END_N;
			end
			default: is_expect = 1'b0;
		endcase
		expect_ok = (rx_byte == expect_ch);
	end

	always_comb begin
		nxt  = cur;
		kind = KIND_NONE;
		if (is_expect) begin
			if (expect_ok) begin
				nxt.phase = expect_next;
			end else begin
				nxt.error_seen = 1'b1;
			end
		end else begin
			case (cur.phase)
				PH_NOT_STARTED: begin
					if (rx_byte != CH_CR && rx_byte != CH_LF) begin
						if (rx_byte != CH_SP) begin
							nxt.method_count = cur.method_count + 1'b1;
							kind             = KIND_METHOD;
						end
						nxt.phase = PH_METHOD;
					end
				end
				PH_METHOD: begin
					if (rx_byte == CH_SP) begin
						nxt.phase = PH_SP_PATH;
					end else if (rx_byte inside {[CH_LO_A:CH_LO_Z]} ||
							cur.method_count >= MAX_CNT) begin
						nxt.error_seen = 1'b1;
					end else begin
						nxt.method_count = cur.method_count + 1'b1;
						kind             = KIND_METHOD;
					end
				end
				PH_SP_PATH: begin
					if (rx_byte != CH_SP) begin
						if (rx_byte == CH_SLASH) begin
							kind      = KIND_PATH;
							nxt.phase = PH_PATH;
						end else begin
							nxt.error_seen = 1'b1;
						end
					end
				end
				PH_PATH: begin
					if (rx_byte != CH_SP) begin
						kind = KIND_PATH;
					end else begin
						nxt.phase = PH_H;
					end
				end
				PH_AFTER: begin
					if (rx_byte == CH_CR) begin
						nxt.phase = PH_END_R;
					end else if (rx_byte == CH_LF) begin
						nxt.phase = PH_END_N;
					end else begin
						nxt.error_seen = 1'b1;
					end
				end
				PH_END_N: begin
					if (rx_byte == CH_CR) begin
						nxt.phase = PH_END;
					end else if (rx_byte != CH_LF) begin
						nxt.phase = PH_HEADER;
						kind      = KIND_HEADER;
					end
				end
				PH_HEADER: kind = KIND_HEADER;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/http_request_line_parser_core.sv =====
// top level of the request line parser: input register, step logic, result register
// items pass from the input register to the result register, which drives m_tvalid
// throughput: one item per cycle while m_tready is high; the input stage refills while the result register drains
// the result register holds a finished item while m_tready is low
// arst_n low clears the parser state to not started, count and error flag to zero
// and empties both stages
`default_nettype none

module http_request_line_parser_core
	import hrlp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // byte_echo, parse_phase, bad_request, line_done, request_end
	output logic [1:0]       m_tuser    // byte_kind
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	logic [7:0]   byte_s2;
	kind_t        kind_s2;
	parse_state_t state_q;
	parse_state_t state_nxt;
	kind_t        kind_nxt;
	logic         advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	hrlp_step u_step (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.kind    (kind_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_NOT_STARTED, method_count: '0, error_seen: 1'b0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			byte_s2 <= byte_s1;
			kind_s2 <= kind_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = kind_s2;
	assign m_tdata  = {
		state_q.phase == PH_END,
		state_q.phase == PH_HEADER || state_q.phase == PH_END,
		state_q.error_seen,
		state_q.phase,
		byte_s2
	};

	// error flag never clears once set
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_seen |=> state_q.error_seen)
		else $error("bad request flag cleared");

	// body phase is never entered
	a_no_body: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase != PH_BODY)
		else $error("parser entered body phase");

	// forwarded header bytes only come out in header phase
	a_header_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_HEADER) |-> (m_tdata[12:8] == PH_HEADER))
		else $error("header byte outside header phase");

	// state only moves when an item passes into the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("parser state changed without an item");

endmodule

`default_nettype wire
